/* rtl/bbsf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbsf_pkg: shared constants and types
// Store depth, field widths, operation codes and the bundles that pass
// between the byte store, the controller and the top level.
// ----------------------------------------------------------------------------
package bbsf_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int LEN_W = 7;
	localparam int OP_W = 3;
	localparam int BYTE_W = 8;
	localparam int TOT_W = 32;

	localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
	localparam logic [OP_W-1:0] OP_END = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK = 3'd2;
	localparam logic [OP_W-1:0] OP_POP = 3'd3;
	localparam logic [OP_W-1:0] OP_READ = 3'd4;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [BYTE_W-1:0] wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} ram_req_t;

	typedef struct packed {
		logic valid;
		logic byte_valid;
		logic last;
		logic accepted;
	} res_flags_t;

	typedef struct packed {
		logic [CNT_W-1:0] fill;
		logic             ended;
		logic             error;
		logic [TOT_W-1:0] wr_total;
		logic [TOT_W-1:0] rd_total;
	} status_t;

	// Ring index plus offset, wrapped at DEPTH; the sum stays below 2*DEPTH.
	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
			input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(idx) + SUM_W'(off);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return IDX_W'(sum);
	endfunction

endpackage

/* rtl/bounded_byte_stream_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_byte_stream_fifo: byte FIFO limited by a capacity register
// Write, end input, peek, pop and read over a ring of bytes in a
// synchronous store; one result per beat on a strobe, status on every beat.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------
//  command   | start / busy              | operation, data_byte, length
//  result    | result_valid (strobe)     | out_byte .. total_read
//  config    | cfg_valid / cfg_ready     | cfg_data (capacity)
//
// Write, end input, pop and unused codes complete on the command beat; a peek
// or a read of more than one byte holds busy while its later bytes stream,
// since the single store read port gives one byte per cycle.
// Each result appears on the cycle after the beat that produced it, so a
// new command can be taken while the previous result is on the ports.
// Reset clears pointers, flags and totals and sets capacity to DEPTH; the
// byte store is not cleared and needs no clearing pass.
// The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module bounded_byte_stream_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [bbsf_pkg::OP_W-1:0]     operation,
	input  logic [bbsf_pkg::BYTE_W-1:0]   data_byte,
	input  logic [bbsf_pkg::LEN_W-1:0]    length,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bbsf_pkg::LEN_W-1:0]    cfg_data,
	output logic                          result_valid,
	output logic [bbsf_pkg::BYTE_W-1:0]   out_byte,
	output logic                          byte_valid,
	output logic                          last,
	output logic                          accepted,
	output logic [bbsf_pkg::LEN_W-1:0]    fill_count,
	output logic [bbsf_pkg::LEN_W-1:0]    room_left,
	output logic                          ended,
	output logic                          end_of_stream,
	output logic                          error_flag,
	output logic [bbsf_pkg::TOT_W-1:0]    total_written,
	output logic [bbsf_pkg::TOT_W-1:0]    total_read
);
	import bbsf_pkg::*;

	logic [LEN_W-1:0]  capacity_q;
	logic [CNT_W-1:0]  eff_cap;
	ram_req_t          ram_req;
	res_flags_t        flags;
	status_t           status;
	logic [BYTE_W-1:0] rdata;

	// Capacity register; the user must write it only while the block is idle (not enforced here).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= LEN_W'(DEPTH);
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// Clamp capacity to the physical depth.
	assign eff_cap = (capacity_q > LEN_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(capacity_q);

	bbsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.data_byte (data_byte),
		.length    (length),
		.eff_cap   (eff_cap),
		.busy      (busy),
		.ram_req   (ram_req),
		.flags     (flags),
		.status    (status)
	);

	bbsf_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rdata)
	);

	// Result beat: flags come registered from the controller, the byte comes
	// straight from the store's read register. Status is already the
	// post-operation state and does not move until the next command beat.
	assign result_valid = flags.valid;
	assign byte_valid = flags.byte_valid;
	assign last = flags.last;
	assign accepted = flags.accepted;
	assign out_byte = flags.byte_valid ? rdata : '0;

	assign fill_count = LEN_W'(status.fill);
	assign room_left = (status.fill < eff_cap) ? LEN_W'(eff_cap - status.fill) : '0;
	assign ended = status.ended;
	assign end_of_stream = status.ended && (status.fill == '0);
	assign error_flag = status.error;
	assign total_written = status.wr_total;
	assign total_read = status.rd_total;

	// A streaming cycle always yields a byte beat on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (result_valid && byte_valid))
		else $error("stream cycle produced no byte beat");

	// The final beat of a command never overlaps an active stream.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |-> !busy)
		else $error("last beat shown while still streaming");

	// Every beat stems from a command beat or a streaming cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($past(start && !busy) || $past(busy)))
		else $error("result beat without a source");

	// A stored byte bumps the write total by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && accepted) |-> (total_written == ($past(total_written) + TOT_W'(1))))
		else $error("accepted write did not count");

	// Fill never exceeds the physical depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		status.fill <= CNT_W'(DEPTH))
		else $error("fill beyond store depth");

endmodule

/* rtl/bbsf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbsf_ram: byte store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bbsf_ram (
	input  logic                      clk,
	input  bbsf_pkg::ram_req_t        req,
	output logic [bbsf_pkg::BYTE_W-1:0] rdata
);
	import bbsf_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

/* rtl/bbsf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbsf_ctrl: pointer, count and operation sequencer
// Applies each operation to head, fill, flags and totals, drives the byte
// store, and streams peek/read bytes one per cycle.
// ----------------------------------------------------------------------------
module bbsf_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bbsf_pkg::OP_W-1:0]     operation,
	input  logic [bbsf_pkg::BYTE_W-1:0]   data_byte,
	input  logic [bbsf_pkg::LEN_W-1:0]    length,
	input  logic [bbsf_pkg::CNT_W-1:0]    eff_cap,
	output logic                          busy,
	output bbsf_pkg::ram_req_t            ram_req,
	output bbsf_pkg::res_flags_t          flags,
	output bbsf_pkg::status_t             status
);
	import bbsf_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_STREAM = 1'b1;

	logic             state_q, state_d;
	logic [IDX_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] fill_q, fill_d;
	logic             ended_q, ended_d;
	logic             error_q, error_d;
	logic [TOT_W-1:0] wr_total_q, wr_total_d;
	logic [TOT_W-1:0] rd_total_q, rd_total_d;
	res_flags_t       flags_q, flags_d;

	logic [IDX_W-1:0] base_q, base_d;
	logic [CNT_W-1:0] num_q, num_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	logic             take;
	logic [CNT_W-1:0] n_avail;

	assign take = start && (state_q == ST_IDLE);
	assign n_avail = (length < LEN_W'(fill_q)) ? CNT_W'(length) : fill_q;

	always_comb begin
		state_d = state_q;
		head_d = head_q;
		fill_d = fill_q;
		ended_d = ended_q;
		error_d = error_q;
		wr_total_d = wr_total_q;
		rd_total_d = rd_total_q;
		base_d = base_q;
		num_d = num_q;
		cnt_d = cnt_q;
		flags_d = '0;
		ram_req = '0;
		ram_req.wdata = data_byte;

		if (state_q == ST_STREAM) begin
			// issue the next byte of the stream
			ram_req.re = 1'b1;
			ram_req.raddr = wrap_add(base_q, cnt_q);
			flags_d.valid = 1'b1;
			flags_d.byte_valid = 1'b1;
			flags_d.last = (cnt_q + CNT_W'(1)) == num_q;
			cnt_d = cnt_q + CNT_W'(1);
			if (flags_d.last) begin
				state_d = ST_IDLE;
			end
		end else if (take) begin
			flags_d.valid = 1'b1;
			flags_d.last = 1'b1;
			case (operation)
				OP_WRITE: begin
					if (error_q || ended_q) begin
						error_d = 1'b1;
					end else if (fill_q < eff_cap) begin
						ram_req.we = 1'b1;
						ram_req.waddr = wrap_add(head_q, fill_q);
						fill_d = fill_q + CNT_W'(1);
						wr_total_d = wr_total_q + TOT_W'(1);
						flags_d.accepted = 1'b1;
					end
				end
				OP_END: begin
					ended_d = 1'b1;
				end
				OP_POP: begin
					head_d = wrap_add(head_q, n_avail);
					fill_d = fill_q - n_avail;
					rd_total_d = rd_total_q + TOT_W'(n_avail);
				end
				default: begin
					if ((operation inside {OP_PEEK, OP_READ}) && (n_avail != '0)) begin
						// first byte now, the rest from the stream state
						ram_req.re = 1'b1;
						ram_req.raddr = head_q;
						flags_d.byte_valid = 1'b1;
						flags_d.last = (n_avail == CNT_W'(1));
						base_d = head_q;
						num_d = n_avail;
						cnt_d = CNT_W'(1);
						if (!flags_d.last) begin
							state_d = ST_STREAM;
						end
					end
					if (operation == OP_READ) begin
						head_d = wrap_add(head_q, n_avail);
						fill_d = fill_q - n_avail;
						rd_total_d = rd_total_q + TOT_W'(n_avail);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			fill_q <= '0;
			ended_q <= 1'b0;
			error_q <= 1'b0;
			wr_total_q <= '0;
			rd_total_q <= '0;
			flags_q <= '0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			fill_q <= fill_d;
			ended_q <= ended_d;
			error_q <= error_d;
			wr_total_q <= wr_total_d;
			rd_total_q <= rd_total_d;
			flags_q <= flags_d;
		end
	end

	always_ff @(posedge clk) begin
		base_q <= base_d;
		num_q <= num_d;
		cnt_q <= cnt_d;
	end

	assign busy = (state_q == ST_STREAM);
	assign flags = flags_q;
	assign status.fill = fill_q;
	assign status.ended = ended_q;
	assign status.error = error_q;
	assign status.wr_total = wr_total_q;
	assign status.rd_total = rd_total_q;

endmodule
